FILE: hdl/quaternion_to_euler_angles_macros.svh
// assertion helpers for the quaternion to euler angle converter
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`ifndef ASSERT_OFF
`define QE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define QE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hdl/qte_pkg.sv
package qte_pkg;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int PROD_W        = 34;
    localparam int CW            = 56;
    localparam int SQ_W          = 61;
    localparam int ROOT_STAGES   = 31;

    typedef logic signed [15:0] t_q15;
    typedef logic signed [ANGLE_BITS-1:0] t_angle;
    typedef logic signed [CW-1:0] t_cval;

    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_XZY = 3'd1,
        ORD_YXZ = 3'd2,
        ORD_YZX = 3'd3,
        ORD_ZXY = 3'd4,
        ORD_ZYX = 3'd5
    } t_order;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163,
        32'd1335087, 32'd667544, 32'd333772, 32'd166886, 32'd83443,
        32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20, 32'd10, 32'd5,
        32'd3, 32'd1, 32'd1, 32'd0
    };

    // table entry rounded half up to the accumulator unit
    function automatic t_angle atan_step(input int idx);
        logic [32:0] v;
        v = {1'b0, ATAN_TAB[idx]};
        if (ANGLE_BITS < 32) begin
            v = v + (33'd1 << (31 - ANGLE_BITS));
            v = v >> (32 - ANGLE_BITS);
        end
        return t_angle'(v);
    endfunction
endpackage

FILE: hdl/qte_if.sv
interface qte_quat_if;
    import qte_pkg::*;
    logic valid;
    logic ready;
    t_q15 quat_x;
    t_q15 quat_y;
    t_q15 quat_z;
    t_q15 quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_angle_if;
    import qte_pkg::*;
    logic valid;
    logic ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface qte_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: hdl/qte_cordic.sv
// pipelined cordic atan2, one iteration per stage, stalls with i_en
module qte_cordic import qte_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_cval  i_y,
    input  t_cval  i_x,
    output t_angle o_angle
);
    t_cval  r_x [CORDIC_STAGES+1];
    t_cval  r_y [CORDIC_STAGES+1];
    t_angle r_a [CORDIC_STAGES+1];
    t_cval  n_x;
    t_cval  n_y;
    t_angle n_a;

    // quadrant fold into the right half plane
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_a = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x = i_y;
                n_y = -i_x;
                n_a = t_angle'(1) <<< (ANGLE_BITS - 2);
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_a = -(t_angle'(1) <<< (ANGLE_BITS - 2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x;
            r_y[0] <= n_y;
            r_a[0] <= n_a;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_a[g+1] <= r_a[g] + atan_step(g);
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_a[g+1] <= r_a[g] - atan_step(g);
                end
            end
        end
    end

    assign o_angle = r_a[CORDIC_STAGES];
endmodule

FILE: hdl/qte_isqrt.sv
// pipelined restoring square root of a 61-bit value, one result bit per stage
module qte_isqrt import qte_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SQ_W-1:0] i_val,
    output logic [30:0]     o_root
);
    logic [SQ_W:0] r_rem  [ROOT_STAGES+1];
    logic [30:0]   r_root [ROOT_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, i_val};
            r_root[0] <= '0;
        end
    end

    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_bit
        localparam int B = ROOT_STAGES - 1 - g;
        logic [SQ_W+1:0] trial;
        assign trial = ({31'd0, r_root[g]} << (B + 1)) + ({(SQ_W+2)'(1)} << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_rem[g]} >= trial) begin
                    r_rem[g+1]  <= r_rem[g] - trial[SQ_W:0];
                    r_root[g+1] <= r_root[g] | (31'd1 << B);
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_STAGES];
endmodule

FILE: hdl/quaternion_to_euler_angles.sv
// Quaternion to Euler angle converter. Takes one unit quaternion (Q1.15) per
// transaction and returns rotations about x, y and z as 16-bit binary angles
// (32768 = pi, +pi reads as -32768) for the order in the config register
// (0 xyz .. 5 zyx, codes 6 and 7 act as xyz). Fully pipelined: a new
// transaction is taken every cycle while the output is not stalled. Each
// transaction passes products, term select, asin clamp and radicand (one
// register each), a 32-stage square root (input register plus 31 bit
// stages), a cordic of 1 + CORDIC_STAGES stages and the output register.
// The atan2 terms wait in delay lines while the square root runs, so all
// three angles leave together. Backpressure stalls the whole pipeline as
// one; input ready follows output ready combinationally.
// Write rotation_order only while idle.
`include "quaternion_to_euler_angles_macros.svh"
module quaternion_to_euler_angles import qte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    qte_quat_if.sink    s_in,
    qte_angle_if.source m_out,
    qte_cfg_if.sink     s_cfg
);
    localparam int SQRT_LAT = ROOT_STAGES + 1;
    localparam int COR_LAT  = CORDIC_STAGES + 1;
    localparam int DEPTH    = 4 + SQRT_LAT + COR_LAT; // products, sums, clamp, square, ...

    t_order r_order;
    logic   r_vld [DEPTH+1];
    logic   en;

    // order register
    assign s_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_XYZ;
        end else if (s_cfg.valid) begin
            r_order <= t_order'(s_cfg.data);
        end
    end

    // pipeline advances when last stage empty or its transaction is taken
    logic out_busy;
    assign out_busy     = r_vld[DEPTH] && !m_out.ready;
    assign en           = !out_busy;
    assign s_in.ready   = en;
    assign m_out.valid  = r_vld[DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= s_in.valid;
            for (int k = 1; k <= DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // stage 1: nine exact products, Q2.30
    logic signed [31:0] r_ii, r_jj, r_kk, r_ei, r_ej, r_ek, r_ij, r_ik, r_jk;
    logic [2:0] r_ord1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ii <= s_in.quat_x * s_in.quat_x;
            r_jj <= s_in.quat_y * s_in.quat_y;
            r_kk <= s_in.quat_z * s_in.quat_z;
            r_ei <= s_in.quat_w * s_in.quat_x;
            r_ej <= s_in.quat_w * s_in.quat_y;
            r_ek <= s_in.quat_w * s_in.quat_z;
            r_ij <= s_in.quat_x * s_in.quat_y;
            r_ik <= s_in.quat_x * s_in.quat_z;
            r_jk <= s_in.quat_y * s_in.quat_z;
            r_ord1 <= r_order;
        end
    end

    // stage 2: order select into two atan2 term sets and one asin term
    logic signed [PROD_W-1:0] n_n0, n_p0, n_n1, n_p1, n_s;
    logic [1:0] n_slot; // which axis takes asin: 0 x, 1 y, 2 z
    function automatic logic signed [PROD_W-1:0] ex(input logic signed [31:0] v);
        return PROD_W'(v);
    endfunction
    function automatic logic signed [PROD_W-1:0] den(input logic signed [31:0] p,
                                                      input logic signed [31:0] q);
        return (PROD_W'(1) <<< 30) - ((ex(p) + ex(q)) <<< 1);
    endfunction
    always_comb begin
        case (r_ord1)
            ORD_XZY: begin
                n_n0 = (ex(r_ei) + ex(r_jk)) <<< 1; n_p0 = den(r_ii, r_kk);
                n_n1 = (ex(r_ej) + ex(r_ik)) <<< 1; n_p1 = den(r_jj, r_kk);
                n_s  = (ex(r_ek) - ex(r_ij)) <<< 1; n_slot = 2'd2;
            end
            ORD_YXZ: begin
                n_n0 = (ex(r_ej) + ex(r_ik)) <<< 1; n_p0 = den(r_ii, r_jj);
                n_n1 = (ex(r_ek) + ex(r_ij)) <<< 1; n_p1 = den(r_ii, r_kk);
                n_s  = (ex(r_ei) - ex(r_jk)) <<< 1; n_slot = 2'd0;
            end
            ORD_YZX: begin
                n_n0 = (ex(r_ei) - ex(r_jk)) <<< 1; n_p0 = den(r_ii, r_kk);
                n_n1 = (ex(r_ej) - ex(r_ik)) <<< 1; n_p1 = den(r_jj, r_kk);
                n_s  = (ex(r_ek) + ex(r_ij)) <<< 1; n_slot = 2'd2;
            end
            ORD_ZXY: begin
                n_n0 = (ex(r_ej) - ex(r_ik)) <<< 1; n_p0 = den(r_ii, r_jj);
                n_n1 = (ex(r_ek) - ex(r_ij)) <<< 1; n_p1 = den(r_ii, r_kk);
                n_s  = (ex(r_ei) + ex(r_jk)) <<< 1; n_slot = 2'd0;
            end
            ORD_ZYX: begin
                n_n0 = (ex(r_ei) + ex(r_jk)) <<< 1; n_p0 = den(r_ii, r_jj);
                n_n1 = (ex(r_ek) + ex(r_ij)) <<< 1; n_p1 = den(r_jj, r_kk);
                n_s  = (ex(r_ej) - ex(r_ik)) <<< 1; n_slot = 2'd1;
            end
            default: begin
                n_n0 = (ex(r_ei) - ex(r_jk)) <<< 1; n_p0 = den(r_ii, r_jj);
                n_n1 = (ex(r_ek) - ex(r_ij)) <<< 1; n_p1 = den(r_jj, r_kk);
                n_s  = (ex(r_ej) + ex(r_ik)) <<< 1; n_slot = 2'd1;
            end
        endcase
    end

    logic signed [PROD_W-1:0] r_n0, r_p0, r_n1, r_p1, r_s;
    logic [1:0] r_slot2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n0 <= n_n0; r_p0 <= n_p0; r_n1 <= n_n1; r_p1 <= n_p1;
            r_s <= n_s; r_slot2 <= n_slot;
        end
    end

    // stage 3: clamp the asin argument to [-1, 1]
    logic signed [31:0] r_sc;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s > (PROD_W'(1) <<< 30)) r_sc <= 32'sd1 <<< 30;
            else if (r_s < -(PROD_W'(1) <<< 30)) r_sc <= -(32'sd1 <<< 30);
            else r_sc <= 32'(r_s);
        end
    end

    // stage 4: 1 - s*s in Q60
    logic [30:0] mag;
    assign mag = r_sc[31] ? 31'(-r_sc) : r_sc[30:0];
    logic [SQ_W-1:0] r_rad;
    always_ff @(posedge i_clk) begin
        if (en) r_rad <= (SQ_W'(1) << 60) - SQ_W'(mag * mag);
    end

    // atan2 operands and the asin argument wait for the square root
    localparam int DLY = 2 + SQRT_LAT;
    logic signed [PROD_W-1:0] r_dn0 [DLY], r_dp0 [DLY], r_dn1 [DLY], r_dp1 [DLY];
    logic signed [31:0] r_ds [SQRT_LAT+1];
    logic [1:0] r_dslot [DLY+COR_LAT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dn0[0] <= r_n0; r_dp0[0] <= r_p0; r_dn1[0] <= r_n1; r_dp1[0] <= r_p1;
            r_dslot[0] <= r_slot2;
            for (int k = 1; k < DLY; k++) begin
                r_dn0[k] <= r_dn0[k-1]; r_dp0[k] <= r_dp0[k-1];
                r_dn1[k] <= r_dn1[k-1]; r_dp1[k] <= r_dp1[k-1];
            end
            for (int k = 1; k < DLY + COR_LAT; k++) r_dslot[k] <= r_dslot[k-1];
            r_ds[0] <= r_sc;
            for (int k = 1; k <= SQRT_LAT; k++) r_ds[k] <= r_ds[k-1];
        end
    end

    logic [30:0] root;
    qte_isqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_val(r_rad), .o_root(root));

    // three cordic lanes; zero vector held apart since it yields angle 0
    t_cval cy0, cx0, cy1, cx1, cy2, cx2;
    assign cy0 = t_cval'(r_dn0[DLY-1]) <<< 20;
    assign cx0 = t_cval'(r_dp0[DLY-1]) <<< 20;
    assign cy1 = t_cval'(r_dn1[DLY-1]) <<< 20;
    assign cx1 = t_cval'(r_dp1[DLY-1]) <<< 20;
    assign cy2 = t_cval'(r_ds[SQRT_LAT]) <<< 20;
    assign cx2 = t_cval'({1'b0, root}) <<< 20;

    logic z0 [COR_LAT], z1 [COR_LAT], z2 [COR_LAT];
    always_ff @(posedge i_clk) begin
        if (en) begin
            z0[0] <= (cy0 == 0) && (cx0 == 0);
            z1[0] <= (cy1 == 0) && (cx1 == 0);
            z2[0] <= (cy2 == 0) && (cx2 == 0);
            for (int k = 1; k < COR_LAT; k++) begin
                z0[k] <= z0[k-1]; z1[k] <= z1[k-1]; z2[k] <= z2[k-1];
            end
        end
    end

    t_angle a0, a1, a2;
    qte_cordic u_cor0 (.i_clk(i_clk), .i_en(en), .i_y(cy0), .i_x(cx0), .o_angle(a0));
    qte_cordic u_cor1 (.i_clk(i_clk), .i_en(en), .i_y(cy1), .i_x(cx1), .o_angle(a1));
    qte_cordic u_cor2 (.i_clk(i_clk), .i_en(en), .i_y(cy2), .i_x(cx2), .o_angle(a2));

    // scale accumulator to 16 bits, rounding half up when wider
    function automatic logic signed [15:0] to_out(input t_angle a, input logic z);
        logic signed [ANGLE_BITS:0] t;
        t = z ? '0 : (ANGLE_BITS+1)'(a);
        if (ANGLE_BITS > 16) begin
            t = t + ((ANGLE_BITS+1)'(1) <<< ((ANGLE_BITS > 16) ? ANGLE_BITS - 17 : 0));
            t = t >>> ((ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0);
            return 16'(t);
        end
        return 16'(t <<< ((ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0));
    endfunction

    logic signed [15:0] o0, o1, o2;
    assign o0 = to_out(a0, z0[COR_LAT-1]);
    assign o1 = to_out(a1, z1[COR_LAT-1]);
    assign o2 = to_out(a2, z2[COR_LAT-1]);

    // output register: route asin to its axis, atan2 results fill the others
    logic [1:0] sl;
    assign sl = r_dslot[DLY+COR_LAT-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            case (sl)
                2'd0: begin
                    m_out.angle_x <= o2; m_out.angle_y <= o0; m_out.angle_z <= o1;
                end
                2'd2: begin
                    m_out.angle_x <= o0; m_out.angle_y <= o1; m_out.angle_z <= o2;
                end
                default: begin
                    m_out.angle_x <= o0; m_out.angle_y <= o2; m_out.angle_z <= o1;
                end
            endcase
        end
    end

    // assertions
    `QE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, out_busy,
        m_out.valid && $stable(m_out.angle_x), "result changed while stalled")
    `QE_ASSERT_IMPLY(a_ready_rule, i_clk, i_rst_n, s_in.ready,
        !m_out.valid || m_out.ready, "ready high while output blocked")
    `QE_ASSERT_NEXT(a_vld_flow, i_clk, i_rst_n, en && !r_vld[DEPTH-1],
        !m_out.valid, "output valid from empty stage")
endmodule

FILE: sim/quaternion_to_euler_angles_tb.sv
module quaternion_to_euler_angles_tb;
    import qte_pkg::*;

    // cycles allowed for the pipeline to empty, plus margin
    localparam int DRAIN_WAIT  = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int N_RANDOM    = 1300;

    typedef struct packed {
        t_q15 x;
        t_q15 y;
        t_q15 z;
        t_q15 w;
    } t_quat;

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
    } t_euler;

    logic i_clk;
    logic i_rst_n;

    qte_quat_if  quat_bus ();
    qte_angle_if angle_bus ();
    qte_cfg_if   cfg_bus ();

    quaternion_to_euler_angles i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (quat_bus.sink),
        .m_out   (angle_bus.source),
        .s_cfg   (cfg_bus.sink)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // pending quaternions and angles still owed by the block
    t_quat  quat_pending[$];
    t_euler angles_owed[$];
    logic [2:0] cur_order;

    int mismatch_cnt;
    int idle_cycles;
    bit hold_quat;
    bit timed_out;

    // ------------------------------------------------------------------
    // fixed point euler angle model
    // ------------------------------------------------------------------

    // floor shift, same as an arithmetic right shift
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int n);
        if (n == 0)
            return v;
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // vectoring mode cordic, angle in ANGLE_BITS units
    function automatic longint cordic_angle(longint yy, longint xx);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        longint stp;
        longint tab;
        acc = 0;
        if (xx == 0 && yy == 0)
            return 0;
        xx = xx * (longint'(1) << 20);
        yy = yy * (longint'(1) << 20);
        if (xx < 0) begin
            t = xx;
            if (yy >= 0) begin
                xx = yy;
                yy = -t;
                acc = longint'(1) << (ANGLE_BITS - 2);
            end else begin
                xx = -yy;
                yy = t;
                acc = -(longint'(1) << (ANGLE_BITS - 2));
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            tab = longint'({32'd0, ATAN_TAB[i]});
            stp = round_half_up(tab, 32 - ANGLE_BITS);
            dx = floor_shift(yy, i);
            dy = floor_shift(xx, i);
            if (yy >= 0) begin
                xx = xx + dx;
                yy = yy - dy;
                acc = acc + stp;
            end else begin
                xx = xx - dx;
                yy = yy + dy;
                acc = acc - stp;
            end
        end
        return acc;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // asin via atan2(s, sqrt(1 - s^2)) with the argument clamped to [-1, 1]
    function automatic longint clamped_asin(longint s);
        longint one;
        longint unsigned sq;
        one = longint'(1) << 30;
        if (s > one)
            s = one;
        if (s < -one)
            s = -one;
        sq = longint'(s < 0 ? -s : s);
        sq = sq * sq;
        return cordic_angle(s, int_sqrt((64'd1 << 60) - sq));
    endfunction

    function automatic longint term_atan2(longint num, longint p, longint q);
        return cordic_angle(2 * num, (longint'(1) << 30) - 2 * (p + q));
    endfunction

    function automatic logic [15:0] angle_to_16(longint acc);
        if (ANGLE_BITS >= 16)
            return 16'(round_half_up(acc, ANGLE_BITS - 16));
        return 16'(acc * (longint'(1) << (16 - ANGLE_BITS)));
    endfunction

    function automatic t_euler quat_to_euler(t_quat q, logic [2:0] order);
        longint x, y, z, w;
        longint ii, jj, kk, ei, ej, ek, ij, ik, jk;
        longint ax, ay, az;
        t_euler r;
        x = q.x; y = q.y; z = q.z; w = q.w;
        ii = x * x; jj = y * y; kk = z * z;
        ei = w * x; ej = w * y; ek = w * z;
        ij = x * y; ik = x * z; jk = y * z;
        case (order)
            ORD_XZY: begin
                ax = term_atan2(ei + jk, ii, kk);
                ay = term_atan2(ej + ik, jj, kk);
                az = clamped_asin(2 * (ek - ij));
            end
            ORD_YXZ: begin
                ax = clamped_asin(2 * (ei - jk));
                ay = term_atan2(ej + ik, ii, jj);
                az = term_atan2(ek + ij, ii, kk);
            end
            ORD_YZX: begin
                ax = term_atan2(ei - jk, ii, kk);
                ay = term_atan2(ej - ik, jj, kk);
                az = clamped_asin(2 * (ek + ij));
            end
            ORD_ZXY: begin
                ax = clamped_asin(2 * (ei + jk));
                ay = term_atan2(ej - ik, ii, jj);
                az = term_atan2(ek - ij, ii, kk);
            end
            ORD_ZYX: begin
                ax = term_atan2(ei + jk, ii, jj);
                ay = clamped_asin(2 * (ej - ik));
                az = term_atan2(ek + ij, jj, kk);
            end
            // xyz, and the unused codes fall back to it
            default: begin
                ax = term_atan2(ei - jk, ii, jj);
                ay = clamped_asin(2 * (ej + ik));
                az = term_atan2(ek - ij, jj, kk);
            end
        endcase
        r.ax = angle_to_16(ax);
        r.ay = angle_to_16(ay);
        r.az = angle_to_16(az);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_q15 rand_q15();
        return t_q15'($urandom_range(0, 65535));
    endfunction

    // near-unit quaternion: random direction scaled to roughly 32767
    function automatic t_quat rand_unit_quat();
        t_quat q;
        real a, b, c, d, n;
        a = real'($urandom_range(0, 65534)) - 32767.0;
        b = real'($urandom_range(0, 65534)) - 32767.0;
        c = real'($urandom_range(0, 65534)) - 32767.0;
        d = real'($urandom_range(0, 65534)) - 32767.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            n = 1.0;
        q.x = t_q15'($rtoi(a * 32767.0 / n));
        q.y = t_q15'($rtoi(b * 32767.0 / n));
        q.z = t_q15'($rtoi(c * 32767.0 / n));
        q.w = t_q15'($rtoi(d * 32767.0 / n));
        return q;
    endfunction

    // gimbal-lock style inputs: two components equal in magnitude
    function automatic t_quat rand_gimbal_quat();
        t_quat q;
        t_q15 v;
        v = t_q15'($urandom_range(23160, 23170));
        q.x = $urandom_range(0, 1) ? v : -v;
        q.y = $urandom_range(0, 1) ? v : -v;
        q.z = t_q15'($urandom_range(0, 40)) - 16'sd20;
        q.w = t_q15'($urandom_range(0, 40)) - 16'sd20;
        if ($urandom_range(0, 1)) begin
            v = q.x; q.x = q.w; q.w = v;
        end
        if ($urandom_range(0, 1)) begin
            v = q.y; q.y = q.z; q.z = v;
        end
        return q;
    endfunction

    function automatic t_quat make_quat(t_q15 x, t_q15 y, t_q15 z, t_q15 w);
        t_quat q;
        q.x = x; q.y = y; q.z = z; q.w = w;
        return q;
    endfunction

    task automatic load_random_items(int count);
        t_quat q;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                q = rand_unit_quat();
            else if (sel < 8)
                q = rand_gimbal_quat();
            else
                q = make_quat(rand_q15(), rand_q15(), rand_q15(), rand_q15());
            quat_pending.push_back(q);
        end
    endtask

    task automatic wait_drained();
        while (quat_pending.size() != 0 || angles_owed.size() != 0 || quat_bus.valid)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write through the config channel, only while the block is idle
    task automatic write_order(logic [2:0] order);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= order;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        cur_order = order;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // driver: pops pending quaternions, random gap before each
    // ------------------------------------------------------------------
    int quat_gap;
    t_quat quat_now;
    bit quat_taken;

    always @(posedge i_clk) begin
        quat_taken <= i_rst_n && quat_bus.valid && quat_bus.ready;
        if (!i_rst_n) begin
            quat_gap <= 0;
        end else if (quat_bus.valid && quat_bus.ready) begin
            // transaction taken: predict with the order in force now
            angles_owed.push_back(quat_to_euler(quat_now, cur_order));
            quat_gap <= $urandom_range(0, 4);
        end else if (!quat_bus.valid && quat_gap > 0) begin
            quat_gap <= quat_gap - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            quat_bus.valid <= 1'b0;
        end else if (quat_bus.valid && !quat_taken) begin
            // hold the offer until the block takes it
        end else if (quat_gap == 0 && !hold_quat && quat_pending.size() != 0
                     && !(quat_bus.valid && quat_bus.ready && quat_pending.size() == 0)) begin
            quat_now = quat_pending.pop_front();
            quat_bus.valid  <= 1'b1;
            quat_bus.quat_x <= quat_now.x;
            quat_bus.quat_y <= quat_now.y;
            quat_bus.quat_z <= quat_now.z;
            quat_bus.quat_w <= quat_now.w;
        end else begin
            quat_bus.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares each angle transaction with the oldest prediction
    // ------------------------------------------------------------------
    int ready_gap;
    t_euler got;
    t_euler want;
    bit angle_taken;

    always @(posedge i_clk) begin
        angle_taken <= i_rst_n && angle_bus.valid && angle_bus.ready;
        if (i_rst_n && angle_bus.valid && angle_bus.ready) begin
            got.ax = angle_bus.angle_x;
            got.ay = angle_bus.angle_y;
            got.az = angle_bus.angle_z;
            if (angles_owed.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected angle transaction x=%0d y=%0d z=%0d",
                             $signed(got.ax), $signed(got.ay), $signed(got.az));
            end else begin
                want = angles_owed.pop_front();
                if (got != want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("angle mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 $signed(want.ax), $signed(want.ay), $signed(want.az),
                                 $signed(got.ax), $signed(got.ay), $signed(got.az));
                end
            end
        end
    end

    // ready drops for a random number of cycles after each transaction
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            angle_bus.ready <= 1'b0;
            ready_gap = 0;
        end else if (angle_taken) begin
            ready_gap = $urandom_range(0, 4);
            angle_bus.ready <= (ready_gap == 0);
        end else if (ready_gap > 0) begin
            ready_gap = ready_gap - 1;
            angle_bus.ready <= (ready_gap == 0);
        end else begin
            angle_bus.ready <= 1'b1;
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (quat_bus.valid && quat_bus.ready)
            || (angle_bus.valid && angle_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("quaternion_to_euler_angles test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [2:0] order_seq [8] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7, 3'd6};

    initial begin
        mismatch_cnt = 0;
        idle_cycles = 0;
        hold_quat = 1'b0;
        timed_out = 1'b0;
        cur_order = ORD_XYZ;
        i_rst_n = 1'b0;
        quat_bus.valid = 1'b0;
        quat_bus.quat_x = '0;
        quat_bus.quat_y = '0;
        quat_bus.quat_z = '0;
        quat_bus.quat_w = '0;
        angle_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items under the reset order: extremes, zero, gimbal lock
        quat_pending.push_back(make_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767));
        quat_pending.push_back(make_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0));
        quat_pending.push_back(make_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0));
        quat_pending.push_back(make_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0));
        quat_pending.push_back(make_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0));
        quat_pending.push_back(make_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0));
        quat_pending.push_back(make_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0));
        quat_pending.push_back(make_quat(16'sd0, 16'sd0, -16'sd32768, -16'sd32768));
        quat_pending.push_back(make_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768));
        quat_pending.push_back(make_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767));
        quat_pending.push_back(make_quat(16'sd23170, 16'sd0, 16'sd0, 16'sd23170));
        quat_pending.push_back(make_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170));
        quat_pending.push_back(make_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0));
        quat_pending.push_back(make_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384));
        quat_pending.push_back(make_quat(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384));
        quat_pending.push_back(make_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768));
        wait_drained();

        // each order, codes 6 and 7 included, with a slice of random items
        foreach (order_seq[k]) begin
            write_order(order_seq[k]);
            quat_pending.push_back(make_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0));
            quat_pending.push_back(make_quat(16'sd0, 16'sd23170, 16'sd23170, 16'sd0));
            quat_pending.push_back(make_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767));
            load_random_items(N_RANDOM / 16);
            // sender holds off until every owed angle has come back
            while (quat_pending.size() > N_RANDOM / 32)
                @(posedge i_clk);
            hold_quat = 1'b1;
            while (angles_owed.size() != 0 || quat_bus.valid)
                @(posedge i_clk);
            hold_quat = 1'b0;
            wait_drained();
        end

        // random orders for the rest, back-to-back stretches included
        for (int k = 0; k < 8; k++) begin
            write_order(3'($urandom_range(0, 7)));
            load_random_items(N_RANDOM / 16);
            wait_drained();
        end
        write_order(ORD_XYZ);
        quat_pending.push_back(make_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1));
        wait_drained();

        if (mismatch_cnt == 0 && angles_owed.size() == 0)
            $display("quaternion_to_euler_angles test passed");
        else
            $display("quaternion_to_euler_angles test failed");
        $finish;
    end
endmodule
